>>> hw/rtl/vpl_pkg.sv
// Shared widths, reset values and register indexes of the volume peak limiter.
package vpl_pkg;

  localparam int SampleW     = 24;
  localparam int ChanW       = 3;
  localparam int GainW       = 22;
  localparam int ThrW        = 24;
  localparam int CoefW       = 24;
  localparam int CfgW        = 24;
  localparam int CfgAddrW    = 2;
  localparam int MagW        = 25;
  localparam int EnvW        = 26;
  localparam int EnvChannels = 2;

  localparam int MulAW = EnvW;
  localparam int MulBW = CoefW;
  localparam int ProdW = MulAW + MulBW;
  localparam int QuotW = MagW;

  localparam logic [GainW-1:0] GainRst   = 22'd1048576;
  localparam logic [ThrW-1:0]  ThrRst    = 24'd8388608;
  localparam logic [CoefW-1:0] AttackRst = 24'd16431297;
  localparam logic [CoefW-1:0] ReleaseRst = 24'd16773721;

  localparam logic [MagW-1:0] NegLimit = 25'h0800000;
  localparam logic [MagW-1:0] PosLimit = 25'h07FFFFF;

  typedef enum logic [CfgAddrW-1:0] {
    CfgVolumeGain     = 2'd0,
    CfgLimitThreshold = 2'd1,
    CfgAttackCoef     = 2'd2,
    CfgReleaseCoef    = 2'd3
  } cfg_reg_e;

endpackage

>>> hw/rtl/vpl_serial_mul.sv
// Radix-4 shift-add multiplier, two multiplier bits per cycle.
module vpl_serial_mul #(
  parameter int AW = vpl_pkg::MulAW,
  parameter int BW = vpl_pkg::MulBW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic [AW+BW-1:0] prod_o,
  output logic             done_o
);

  localparam int Digits = BW / 2;
  localparam int CntW   = (Digits > 1) ? $clog2(Digits) : 1;

  logic             busy_q, prep_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [AW-1:0]    a_q;
  logic [AW+1:0]    a3_q;
  logic [AW+BW-1:0] p_q;
  logic [AW+1:0]    pp;
  logic [AW+1:0]    sum;

  always_comb begin
    case (p_q[1:0])
      2'd0:    pp = '0;
      2'd1:    pp = (AW+2)'(a_q);
      2'd2:    pp = {1'b0, a_q, 1'b0};
      default: pp = a3_q;
    endcase
    sum = (AW+2)'(p_q[AW+BW-1:BW]) + pp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      prep_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        prep_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q && prep_q) begin
        prep_q <= 1'b0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(Digits - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      p_q <= {{AW{1'b0}}, b_i};
    end else if (busy_q && prep_q) begin
      a3_q <= (AW+2)'(a_q) + {1'b0, a_q, 1'b0};
    end else if (busy_q) begin
      p_q <= {sum, p_q[BW-1:2]};
    end
  end

  assign prod_o = p_q;
  assign done_o = done_q;

endmodule

>>> hw/rtl/vpl_serial_div.sv
// Restoring divider, one quotient bit per cycle.
module vpl_serial_div #(
  parameter int NW = vpl_pkg::ProdW,
  parameter int DW = vpl_pkg::EnvW,
  parameter int QW = vpl_pkg::QuotW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic [QW-1:0] quot_o,
  output logic          done_o
);

  localparam int CntW = $clog2(QW + 1);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DW-1:0]   rem_q, d_q, rem_d;
  logic [QW-1:0]   n_q;
  logic [DW:0]     trial;
  logic            qbit;

  always_comb begin
    trial = {rem_q, n_q[QW-1]};
    qbit  = (trial >= {1'b0, d_q});
    rem_d = qbit ? DW'(trial - {1'b0, d_q}) : DW'(trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(QW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DW'(dividend_i[NW-1:QW]);
      n_q   <= dividend_i[QW-1:0];
      d_q   <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      n_q   <= {n_q[QW-2:0], qbit};
    end
  end

  assign quot_o = n_q;
  assign done_o = done_q;

endmodule

>>> hw/rtl/volume_peak_limiter.sv
// Gain stage and attack/release peak limiter, top level.
// One request is processed at a time: the gain product, the envelope step and the
// threshold product each go through a shared two-bit-per-cycle multiplier, and the
// threshold/envelope quotient through a one-bit-per-cycle divider, used only when
// the envelope exceeds the threshold. The next request can be taken once the result
// is loaded, and loading waits until the output register is free. The next request is
// taken while the previous result still waits in the output register.
// Channels at or above ENV_CHANNELS share the last envelope.
module volume_peak_limiter #(
  parameter int ENV_CHANNELS = vpl_pkg::EnvChannels
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [vpl_pkg::CfgAddrW-1:0]       cfg_addr_i,
  input  logic [vpl_pkg::CfgW-1:0]           cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [vpl_pkg::SampleW-1:0] sample_in_i,
  input  logic [vpl_pkg::ChanW-1:0]          channel_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [vpl_pkg::SampleW-1:0] sample_out_o
);

  localparam int IdxW = (ENV_CHANNELS > 1) ? $clog2(ENV_CHANNELS) : 1;
  localparam int SW   = vpl_pkg::SampleW;
  localparam int EW   = vpl_pkg::EnvW;
  localparam int MW   = vpl_pkg::MagW;
  localparam int PW   = vpl_pkg::ProdW;

  typedef enum logic [8:0] {
    StIdle = 9'b000000001,
    StGain = 9'b000000010,
    StPrep = 9'b000000100,
    StEnv  = 9'b000001000,
    StUpd  = 9'b000010000,
    StChk  = 9'b000100000,
    StLim  = 9'b001000000,
    StDiv  = 9'b010000000,
    StOut  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [vpl_pkg::GainW-1:0] gain_q;
  logic [vpl_pkg::ThrW-1:0]  thr_q;
  logic [vpl_pkg::CoefW-1:0] attack_q, release_q;

  logic [EW-1:0]   env_q [ENV_CHANNELS];
  logic [IdxW-1:0] idx_q, idx_in;
  logic            neg_q, ge_q;
  logic [MW-1:0]   m_q;
  logic [EW-1:0]   e_q, step_q, env_new_q;
  logic            out_valid_q;
  logic [SW-1:0]   out_data_q;

  logic [SW-1:0]            smag_in;
  logic [EW-1:0]            e_cur, m_ext, diff, env_new, m_full, step_full;
  logic                     ge_cur, lim_needed, out_free;
  logic [vpl_pkg::CoefW-1:0] coef_sel;
  logic [SW-1:0]            res;

  logic                     mul_start;
  logic [vpl_pkg::MulAW-1:0] mul_a;
  logic [vpl_pkg::MulBW-1:0] mul_b;
  logic [PW-1:0]            mul_prod;
  logic                     mul_done;

  logic                     div_start;
  logic [PW-1:0]            div_dividend;
  logic [vpl_pkg::QuotW-1:0] div_quot;
  logic                     div_done;

  assign smag_in = sample_in_i[SW-1] ? (SW'(0) - $unsigned(sample_in_i)) : $unsigned(sample_in_i);
  assign idx_in  = ({1'b0, channel_i} < (vpl_pkg::ChanW+1)'(ENV_CHANNELS)) ?
                   IdxW'(channel_i) : IdxW'(ENV_CHANNELS - 1);

  assign e_cur    = env_q[idx_q];
  assign m_ext    = EW'(m_q);
  assign ge_cur   = (e_cur >= m_ext);
  assign diff     = ge_cur ? (e_cur - m_ext) : (m_ext - e_cur);
  assign coef_sel = ge_cur ? release_q : attack_q;
  assign env_new  = ge_q ? (m_ext + step_q) : (m_ext - step_q);

  assign m_full    = mul_prod[45:20] + EW'(mul_prod[19]);
  assign step_full = mul_prod[PW-1:24] + EW'(mul_prod[23]);

  assign lim_needed   = (thr_q != '0) && (env_new_q > EW'(thr_q));
  assign out_free     = !out_valid_q || out_ready_i;
  assign in_ready_o   = (state_q == StIdle);
  assign div_start    = (state_q == StLim) && mul_done;
  assign div_dividend = mul_prod + PW'(env_new_q[EW-1:1]);

  always_comb begin
    if (neg_q) begin
      res = SW'(0) - ((m_q > vpl_pkg::NegLimit) ? SW'(vpl_pkg::NegLimit) : m_q[SW-1:0]);
    end else begin
      res = (m_q > vpl_pkg::PosLimit) ? SW'(vpl_pkg::PosLimit) : m_q[SW-1:0];
    end
  end

  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_q)
      StIdle: begin
        mul_start = in_valid_i;
        mul_a     = vpl_pkg::MulAW'(smag_in);
        mul_b     = vpl_pkg::MulBW'(gain_q);
      end
      StPrep: begin
        mul_start = 1'b1;
        mul_a     = diff;
        mul_b     = coef_sel;
      end
      StChk: begin
        mul_start = lim_needed;
        mul_a     = m_ext;
        mul_b     = thr_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_valid_i) state_d = StGain;
      StGain: if (mul_done) state_d = StPrep;
      StPrep: state_d = StEnv;
      StEnv:  if (mul_done) state_d = StUpd;
      StUpd:  state_d = StChk;
      StChk:  state_d = lim_needed ? StLim : StOut;
      StLim:  if (mul_done) state_d = StDiv;
      StDiv:  if (div_done) state_d = StOut;
      StOut:  if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      gain_q      <= vpl_pkg::GainRst;
      thr_q       <= vpl_pkg::ThrRst;
      attack_q    <= vpl_pkg::AttackRst;
      release_q   <= vpl_pkg::ReleaseRst;
      for (int i = 0; i < ENV_CHANNELS; i++) begin
        env_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (vpl_pkg::cfg_reg_e'(cfg_addr_i))
          vpl_pkg::CfgVolumeGain:     gain_q    <= cfg_wdata_i[vpl_pkg::GainW-1:0];
          vpl_pkg::CfgLimitThreshold: thr_q     <= cfg_wdata_i[vpl_pkg::ThrW-1:0];
          vpl_pkg::CfgAttackCoef:     attack_q  <= cfg_wdata_i[vpl_pkg::CoefW-1:0];
          vpl_pkg::CfgReleaseCoef:    release_q <= cfg_wdata_i[vpl_pkg::CoefW-1:0];
          default: ;
        endcase
      end
      if (state_q == StUpd) begin
        env_q[idx_q] <= env_new;
      end
      if (state_q == StOut && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      neg_q <= sample_in_i[SW-1];
      idx_q <= idx_in;
    end
    if (state_q == StGain && mul_done) begin
      m_q <= MW'(m_full);
    end
    if (state_q == StPrep) begin
      e_q  <= e_cur;
      ge_q <= ge_cur;
    end
    if (state_q == StEnv && mul_done) begin
      step_q <= step_full;
    end
    if (state_q == StUpd) begin
      env_new_q <= env_new;
    end
    if (state_q == StDiv && div_done) begin
      m_q <= div_quot;
    end
    if (state_q == StOut && out_free) begin
      out_data_q <= res;
    end
  end

  vpl_serial_mul #(
    .AW (vpl_pkg::MulAW),
    .BW (vpl_pkg::MulBW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (mul_prod),
    .done_o  (mul_done)
  );

  vpl_serial_div #(
    .NW (PW),
    .DW (EW),
    .QW (vpl_pkg::QuotW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (env_new_q),
    .quot_o     (div_quot),
    .done_o     (div_done)
  );

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = $signed(out_data_q);

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_out_from_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StOut))
    else $error("result raised outside the output state");

  a_env_between: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StChk) |->
      ((env_new_q >= m_ext && env_new_q <= e_q) || (env_new_q <= m_ext && env_new_q >= e_q)))
    else $error("envelope update left the span of level and old envelope");

  a_quot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv && div_done) |-> (div_quot <= m_q))
    else $error("limited level above gained level");

endmodule

>>> sim/tb_top.sv
// Testbench for volume_peak_limiter: directed and random requests against a predictor.
module tb_top;
  import vpl_pkg::*;

  localparam int WatchLimit = 4000;
  localparam int TailCycles = 80;

  typedef enum logic {
    RowSample,
    RowWrite
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    cfg_reg_e    reg_idx;
    logic [23:0] value;
    logic [2:0]  chan;
    logic        typed;
    logic [23:0] result;
  } dir_row_t;

  localparam int NumRows = 33;
  localparam dir_row_t DirRows [NumRows] = '{
    '{RowSample, CfgVolumeGain,     24'd0,        3'd0, 1'b1, 24'd0},
    '{RowSample, CfgVolumeGain,     24'h7FFFFF,   3'd0, 1'b1, 24'h7FFFFF},
    '{RowSample, CfgVolumeGain,     24'h800000,   3'd1, 1'b1, 24'h800000},
    '{RowSample, CfgVolumeGain,     24'h000001,   3'd7, 1'b0, 24'd0},
    '{RowSample, CfgVolumeGain,     24'hFFFFFF,   3'd2, 1'b0, 24'd0},
    '{RowWrite,  CfgVolumeGain,     24'd0,        3'd0, 1'b0, 24'd0},
    '{RowSample, CfgVolumeGain,     24'h7FFFFF,   3'd0, 1'b1, 24'd0},
    '{RowSample, CfgVolumeGain,     24'h800000,   3'd3, 1'b1, 24'd0},
    '{RowWrite,  CfgVolumeGain,     24'd4194303,  3'd0, 1'b0, 24'd0},
    '{RowWrite,  CfgLimitThreshold, 24'd0,        3'd0, 1'b0, 24'd0},
    '{RowSample, CfgVolumeGain,     24'h7FFFFF,   3'd0, 1'b1, 24'h7FFFFF},
    '{RowSample, CfgVolumeGain,     24'h800000,   3'd1, 1'b1, 24'h800000},
    '{RowSample, CfgVolumeGain,     24'h400000,   3'd0, 1'b0, 24'd0},
    '{RowWrite,  CfgAttackCoef,     24'd0,        3'd0, 1'b0, 24'd0},
    '{RowWrite,  CfgReleaseCoef,    24'd0,        3'd0, 1'b0, 24'd0},
    '{RowWrite,  CfgLimitThreshold, 24'd4194304,  3'd0, 1'b0, 24'd0},
    '{RowWrite,  CfgVolumeGain,     24'd1048576,  3'd0, 1'b0, 24'd0},
    '{RowSample, CfgVolumeGain,     24'h7FFFFF,   3'd0, 1'b0, 24'd0},
    '{RowSample, CfgVolumeGain,     24'h800000,   3'd6, 1'b0, 24'd0},
    '{RowSample, CfgVolumeGain,     24'h200000,   3'd0, 1'b0, 24'd0},
    '{RowWrite,  CfgLimitThreshold, 24'd16777215, 3'd0, 1'b0, 24'd0},
    '{RowWrite,  CfgVolumeGain,     24'd4194303,  3'd0, 1'b0, 24'd0},
    '{RowSample, CfgVolumeGain,     24'h7FFFFF,   3'd0, 1'b0, 24'd0},
    '{RowSample, CfgVolumeGain,     24'h800000,   3'd5, 1'b0, 24'd0},
    '{RowWrite,  CfgAttackCoef,     24'd16777215, 3'd0, 1'b0, 24'd0},
    '{RowWrite,  CfgReleaseCoef,    24'd16777215, 3'd0, 1'b0, 24'd0},
    '{RowWrite,  CfgLimitThreshold, 24'd1,        3'd0, 1'b0, 24'd0},
    '{RowSample, CfgVolumeGain,     24'h123456,   3'd0, 1'b0, 24'd0},
    '{RowSample, CfgVolumeGain,     24'hEDCBA9,   3'd4, 1'b0, 24'd0},
    '{RowWrite,  CfgLimitThreshold, 24'd8388608,  3'd0, 1'b0, 24'd0},
    '{RowWrite,  CfgVolumeGain,     24'd1048576,  3'd0, 1'b0, 24'd0},
    '{RowSample, CfgVolumeGain,     24'h555555,   3'd1, 1'b0, 24'd0},
    '{RowSample, CfgVolumeGain,     24'hAAAAAA,   3'd0, 1'b0, 24'd0}
  };

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CfgAddrW-1:0]       cfg_addr_i;
  logic [CfgW-1:0]           cfg_wdata_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic signed [SampleW-1:0] sample_in_i;
  logic [ChanW-1:0]          channel_i;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [SampleW-1:0] sample_out_o;

  logic [GainW-1:0]  gain_q;
  logic [ThrW-1:0]   thr_q;
  logic [CoefW-1:0]  attack_q;
  logic [CoefW-1:0]  release_q;
  logic [EnvW-1:0]   env_q [EnvChannels];

  logic [SampleW-1:0] out_due_q [$];
  int                 err_count = 0;
  int                 quiet_cycles = 0;
  int                 send_gap_pct = 18;
  int                 recv_stall_pct = 47;

  volume_peak_limiter u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_in_i  (sample_in_i),
    .channel_i    (channel_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Gain, envelope update, threshold scaling and saturation of one sample.
  function automatic logic [SampleW-1:0] limit_sample(input logic [SampleW-1:0] raw,
                                                      input logic [ChanW-1:0] ch);
    logic        neg;
    int          idx;
    logic [63:0] smag;
    logic [63:0] mag;
    logic [63:0] env;
    logic [63:0] coef;
    logic [63:0] stp;
    neg  = raw[SampleW-1];
    smag = neg ? (64'h1000000 - 64'(raw)) : 64'(raw);
    idx  = (int'(ch) < EnvChannels) ? int'(ch) : EnvChannels - 1;
    mag  = (smag * 64'(gain_q) + (64'd1 << 19)) >> 20;
    env  = 64'(env_q[idx]);
    coef = (mag > env) ? 64'(attack_q) : 64'(release_q);
    if (env >= mag) begin
      stp = (coef * (env - mag) + (64'd1 << 23)) >> 24;
      env = mag + stp;
    end else begin
      stp = (coef * (mag - env) + (64'd1 << 23)) >> 24;
      env = mag - stp;
    end
    env = env & 64'h3FFFFFF;
    env_q[idx] = env[EnvW-1:0];
    if (thr_q != '0 && env > 64'(thr_q)) begin
      mag = (mag * 64'(thr_q) + (env >> 1)) / env;
    end
    if (neg) begin
      if (mag > 64'h800000) mag = 64'h800000;
      mag = 64'h1000000 - mag;
    end else if (mag > 64'h7FFFFF) begin
      mag = 64'h7FFFFF;
    end
    return mag[SampleW-1:0];
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CfgVolumeGain:     gain_q    = val[GainW-1:0];
      CfgLimitThreshold: thr_q     = val[ThrW-1:0];
      CfgAttackCoef:     attack_q  = val[CoefW-1:0];
      CfgReleaseCoef:    release_q = val[CoefW-1:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_request(input logic [SampleW-1:0] smp, input logic [ChanW-1:0] ch,
                              input logic typed, input logic [SampleW-1:0] typed_out);
    logic [SampleW-1:0] pred;
    if ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_gap_pct);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= smp;
    channel_i   <= ch;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    pred = limit_sample(smp, ch);
    out_due_q.push_back(typed ? typed_out : pred);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (out_due_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [CoefW-1:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return AttackRst;
      3: return ReleaseRst;
      4: return CoefW'($urandom());
      default: return CoefW'($urandom_range(15000000, 16777215));
    endcase
  endfunction

  function automatic logic [SampleW-1:0] burst_sample(input int amp);
    int mag;
    case ($urandom_range(0, 9))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return SampleW'($urandom());
      default: begin
        mag = $urandom_range(0, amp);
        return $urandom_range(0, 1) ? SampleW'(-mag) : SampleW'(mag);
      end
    endcase
  endfunction

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin : out_check
    logic [SampleW-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (out_due_q.size() == 0) begin
        $error("sample_out: expected nothing, got %0d", sample_out_o);
        err_count++;
      end else begin
        want = out_due_q.pop_front();
        if (sample_out_o !== want) begin
          $error("sample_out: expected %0d, got %0d", $signed(want), sample_out_o);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int          sent;
    int          amp;
    int          len;
    logic [2:0]  ch;
    logic [23:0] thr;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_addr_i  = '0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    sample_in_i = '0;
    channel_i   = '0;
    gain_q      = GainRst;
    thr_q       = ThrRst;
    attack_q    = AttackRst;
    release_q   = ReleaseRst;
    foreach (env_q[i]) env_q[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirRows[i]) begin
      if (DirRows[i].kind == RowWrite) begin
        wait_idle();
        write_reg(DirRows[i].reg_idx, DirRows[i].value);
      end else begin
        send_request(DirRows[i].value, DirRows[i].chan, DirRows[i].typed, DirRows[i].result);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_gap_pct   = (ph == 0) ? 18 : (ph == 1) ? 47 : 0;
      recv_stall_pct = (ph == 0) ? 47 : (ph == 1) ? 18 : 0;
      for (int b = 0; b < 4; b++) begin
        wait_idle();
        case ($urandom_range(0, 5))
          0: write_reg(CfgVolumeGain, 24'd0);
          1: write_reg(CfgVolumeGain, 24'd4194303);
          2: write_reg(CfgVolumeGain, 24'(GainRst));
          default: write_reg(CfgVolumeGain, 24'($urandom_range(0, 4194303)));
        endcase
        case ($urandom_range(0, 5))
          0: thr = '0;
          1: thr = 24'd8388608;
          2: thr = 24'($urandom());
          default: thr = 24'($urandom_range(262144, 8388608));
        endcase
        write_reg(CfgLimitThreshold, thr);
        write_reg(CfgAttackCoef, pick_coef());
        write_reg(CfgReleaseCoef, pick_coef());
        sent = 0;
        while (sent < 46) begin
          if ($urandom_range(0, 4) == 0) begin
            send_request(24'($urandom()), 3'($urandom_range(0, 7)), 1'b0, '0);
            sent++;
          end else begin
            ch = 3'($urandom_range(0, 7));
            case ($urandom_range(0, 3))
              0: amp = 8388607;
              1: amp = $urandom_range(0, 1000);
              default: amp = $urandom_range(0, 8388607);
            endcase
            len = $urandom_range(1, 12);
            if (len > 46 - sent) len = 46 - sent;
            repeat (len) send_request(burst_sample(amp), ch, 1'b0, '0);
            sent += len;
          end
        end
      end
    end

    wait_idle();
    repeat (TailCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
